// ===== design/assert_macros.svh =====
// assertion macros used by the rtl file bounded_recency_list_push.sv
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/brlp_pkg.sv =====
// shared types and constants of the bounded recency list
// no dependencies
`default_nettype none

package brlp_pkg;

    localparam int CFG_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic match_en;   // compare against the pushed key
        logic shift_all;  // every cell takes its newer neighbour
        logic ins_en;     // write the pushed key at ins_pos
    } brlp_ctl_t;

endpackage

`default_nettype wire

// ===== design/brlp_cell.sv =====
// one position of the recency list: key register, compare, close-up shift
// depends on brlp_pkg
`default_nettype none

module brlp_cell #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32,
    parameter int INDEX     = 0
) (
    input  wire logic                              aclk,
    input  wire brlp_pkg::brlp_ctl_t               ctl,
    input  wire logic [$clog2(CAPACITY+1)-1:0]     count_in,
    input  wire logic [$clog2(CAPACITY+1)-1:0]     ins_pos,
    input  wire logic [KEY_WIDTH-1:0]              push_key,
    input  wire logic [KEY_WIDTH-1:0]              nb_key,
    input  wire logic                              seen_in,
    output logic      [KEY_WIDTH-1:0]              key_out,
    output logic                                   seen_out
);
    import brlp_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 occupied;
    logic                 match;

    assign occupied = CW'(INDEX) < count_in;
    assign match    = ctl.match_en && occupied && (key_reg == push_key);
    // set from the matching position upwards: those cells close the gap
    assign seen_out = seen_in | match;

    always_comb begin
        if (ctl.ins_en && (ins_pos == CW'(INDEX))) begin
            key_next = push_key;
        end else if (ctl.shift_all || seen_out) begin
            key_next = nb_key;
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

endmodule

`default_nettype wire

// ===== design/bounded_recency_list_push.sv =====
// top level of the bounded recency list: push sequencer, limit register, cell row
// depends on brlp_pkg, brlp_cell and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Keeps up to CAPACITY distinct keys, oldest first, in a row of cells that
// compare the pushed key in parallel and close up by one position per cycle.
// A push is normally finished in the idle state, and one beat can be accepted every
// cycle while the result side keeps up; a single output register sits between the
// two sides. When max_entries has been lowered below the stored count, the next push
// removes and appends, then evicts one further oldest entry per trim step (the cell
// row shifts one place per cycle), then posts the result; no beat is accepted meanwhile.
// max_entries of 0 acts as 1, above CAPACITY as CAPACITY.
// Stored keys need no clearing after reset.
module bounded_recency_list_push #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [brlp_pkg::CFG_W-1:0]            cfg_wr_data,  // max_entries
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((KEY_WIDTH+7)/8)*8-1:0]        s_tdata,      // push_key
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // was_present, evicted_count[5], evicted_key[KEY_WIDTH], entry_count_out[5]
    output logic      [((KEY_WIDTH+11+7)/8)*8-1:0]     m_tdata
);
    import brlp_pkg::*;

    localparam int CW    = $clog2(CAPACITY+1);
    localparam int OUT_W = ((KEY_WIDTH+11+7)/8)*8;

    typedef enum logic [1:0] {ST_IDLE, ST_TRIM, ST_FLUSH} state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       max_entries_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          remain_reg;
    logic [CW-1:0]          evc_reg;
    logic [KEY_WIDTH-1:0]   evkey_reg;
    logic                   found_reg;
    logic                   m_valid_reg;
    logic                   out_was_reg;
    logic [CNT_OUT_W-1:0]   out_evc_reg;
    logic [KEY_WIDTH-1:0]   out_evk_reg;
    logic [CNT_OUT_W-1:0]   out_cnt_reg;

    logic [CW-1:0]          lim;
    logic [KEY_WIDTH-1:0]   push_key;
    logic [KEY_WIDTH-1:0]   keys [CAPACITY];
    logic                   seen [CAPACITY+1];
    logic                   found;
    logic                   full_hit;
    logic                   accept;
    logic                   slot_free;
    brlp_ctl_t              ctl;
    logic [CW-1:0]          ins_pos;

    assign push_key  = s_tdata[KEY_WIDTH-1:0];
    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign found     = seen[CAPACITY];
    assign full_hit  = count_reg >= lim;

    always_comb begin
        if (max_entries_reg == '0) begin
            lim = CW'(1);
        end else if (int'(max_entries_reg) > CAPACITY) begin
            lim = CW'(CAPACITY);
        end else begin
            lim = CW'(max_entries_reg);
        end
    end

    always_comb begin
        ctl     = '0;
        ins_pos = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctl.match_en  = 1'b1;
                    // a miss on a full list drops the oldest as the key goes in
                    ctl.shift_all = !found && full_hit;
                    ctl.ins_en    = 1'b1;
                    ins_pos       = (found || full_hit) ? count_reg - 1'b1 : count_reg;
                end
            end
            ST_TRIM: begin
                ctl.shift_all = 1'b1;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_WIDTH-1:0] nb;
        if (i == CAPACITY-1) begin : g_end
            assign nb = keys[i];
        end else begin : g_mid
            assign nb = keys[i+1];
        end
        brlp_cell #(
            .CAPACITY  (CAPACITY),
            .KEY_WIDTH (KEY_WIDTH),
            .INDEX     (i)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .count_in (count_reg),
            .ins_pos  (ins_pos),
            .push_key (push_key),
            .nb_key   (nb),
            .seen_in  (seen[i]),
            .key_out  (keys[i]),
            .seen_out (seen[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_entries_reg <= MAX_ENTRIES_RST;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_entries_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (found) begin
                            if (count_reg > lim) begin
                                state_reg  <= ST_TRIM;
                                remain_reg <= count_reg - lim;
                                evc_reg    <= '0;
                                evkey_reg  <= '0;
                                found_reg  <= 1'b1;
                            end else begin
                                m_valid_reg <= 1'b1;
                                out_was_reg <= 1'b1;
                                out_evc_reg <= '0;
                                out_evk_reg <= '0;
                                out_cnt_reg <= CNT_OUT_W'(count_reg);
                            end
                        end else if (full_hit) begin
                            if (count_reg == lim) begin
                                m_valid_reg <= 1'b1;
                                out_was_reg <= 1'b0;
                                out_evc_reg <= CNT_OUT_W'(1);
                                out_evk_reg <= keys[0];
                                out_cnt_reg <= CNT_OUT_W'(count_reg);
                            end else begin
                                state_reg  <= ST_TRIM;
                                remain_reg <= count_reg - lim;
                                evc_reg    <= CW'(1);
                                evkey_reg  <= keys[0];
                                found_reg  <= 1'b0;
                            end
                        end else begin
                            count_reg   <= count_reg + 1'b1;
                            m_valid_reg <= 1'b1;
                            out_was_reg <= 1'b0;
                            out_evc_reg <= '0;
                            out_evk_reg <= '0;
                            out_cnt_reg <= CNT_OUT_W'(count_reg + 1'b1);
                        end
                    end
                end
                ST_TRIM: begin
                    // the oldest cell leaves the row this cycle
                    evkey_reg  <= keys[0];
                    evc_reg    <= evc_reg + 1'b1;
                    count_reg  <= count_reg - 1'b1;
                    remain_reg <= remain_reg - 1'b1;
                    if (remain_reg == CW'(1)) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (slot_free) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b1;
                        out_was_reg <= found_reg;
                        out_evc_reg <= CNT_OUT_W'(evc_reg);
                        out_evk_reg <= evkey_reg;
                        out_cnt_reg <= CNT_OUT_W'(count_reg);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_cnt_reg, out_evk_reg, out_evc_reg, out_was_reg});

    // each trim step drops exactly one entry
    `ASSERT_CLK(a_trim_step, aclk, aresetn, (state_reg == ST_TRIM) |=> (count_reg == $past(count_reg) - 1'b1))
    // a push finished at once never leaves more entries than the limit
    `ASSERT_CLK(a_one_cycle_limit, aclk, aresetn, (s_tvalid && s_tready) |=> ((state_reg != ST_IDLE) || (count_reg <= $past(lim))))
    // trimming always has work left
    `ASSERT_CLK(a_trim_remain, aclk, aresetn, (state_reg == ST_TRIM) |-> (remain_reg != '0))

endmodule

`default_nettype wire

// ===== verif/brlp_push_checker.sv =====
// watcher for the bounded recency list: tracks config writes and accepted pushes,
// predicts each result beat and compares it with what the block returns
// depends on brlp_pkg
`default_nettype none

module brlp_push_checker #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [brlp_pkg::CFG_W-1:0]            cfg_wr_data,
    input  wire logic                                  s_tvalid,
    input  wire logic                                  s_tready,
    input  wire logic [((KEY_WIDTH+7)/8)*8-1:0]        s_tdata,
    input  wire logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic [((KEY_WIDTH+11+7)/8)*8-1:0]     m_tdata,
    output int                                         mismatch_count,
    output int                                         results_owed
);

    localparam int RES_W = KEY_WIDTH + 11;
    localparam int OUT_W = ((KEY_WIDTH + 11 + 7) / 8) * 8;

    // first member lands in the top bits, so the order is reversed from the port comment
    typedef struct packed {
        logic [brlp_pkg::CNT_OUT_W-1:0] entry_count_out;
        logic [KEY_WIDTH-1:0]           evicted_key;
        logic [brlp_pkg::CNT_OUT_W-1:0] evicted_count;
        logic                           was_present;
    } push_result_t;

    logic [KEY_WIDTH-1:0]       recency_keys [CAPACITY];
    int                         held_count;
    logic [brlp_pkg::CFG_W-1:0] limit_reg;
    push_result_t               owed_results [$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
        held_count     = 0;
        limit_reg      = brlp_pkg::MAX_ENTRIES_RST;
    end

    task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // move or append the key, then trim the oldest entries down to the limit
    task automatic apply_push(input logic [KEY_WIDTH-1:0] key, output push_result_t res);
        logic [KEY_WIDTH-1:0] work [CAPACITY+1];
        int                   n;
        int                   drop;
        int                   lim;
        int                   i;
        logic                 hit;
        n    = 0;
        drop = 0;
        hit  = 1'b0;
        lim  = (limit_reg == 0) ? 1 : ((limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg));
        for (i = 0; i < held_count; i++) begin
            if (recency_keys[i] == key) begin
                hit = 1'b1;
            end else begin
                work[n] = recency_keys[i];
                n++;
            end
        end
        work[n] = key;
        n++;
        res = '0;
        if (n > lim) begin
            drop            = n - lim;
            res.evicted_key = work[drop-1];
        end
        for (i = 0; i < n - drop; i++)
            recency_keys[i] = work[i+drop];
        held_count          = n - drop;
        res.was_present     = hit;
        res.evicted_count   = drop[brlp_pkg::CNT_OUT_W-1:0];
        res.entry_count_out = held_count[brlp_pkg::CNT_OUT_W-1:0];
    endtask

    always @(posedge aclk) begin
        push_result_t want;
        push_result_t seen;
        if (!aresetn) begin
            owed_results.delete();
            held_count = 0;
            limit_reg  = brlp_pkg::MAX_ENTRIES_RST;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[RES_W-1:0];
                if (owed_results.size() == 0) begin
                    flag_field("unexpected result beat", '0, m_tdata);
                end else begin
                    want = owed_results.pop_front();
                    if (seen.was_present != want.was_present)
                        flag_field("was_present", want.was_present, seen.was_present);
                    if (seen.evicted_count != want.evicted_count)
                        flag_field("evicted_count", want.evicted_count, seen.evicted_count);
                    if (seen.evicted_key != want.evicted_key)
                        flag_field("evicted_key", want.evicted_key, seen.evicted_key);
                    if (seen.entry_count_out != want.entry_count_out)
                        flag_field("entry_count_out", want.entry_count_out,
                                   seen.entry_count_out);
                end
                if (m_tdata[OUT_W-1:RES_W] != '0)
                    flag_field("tdata padding", '0, m_tdata[OUT_W-1:RES_W]);
            end
            if (s_tvalid && s_tready) begin
                apply_push(s_tdata[KEY_WIDTH-1:0], want);
                owed_results.push_back(want);
            end
            // a write lands at this edge, so a push at the same edge still saw the old limit
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
        end
        results_owed = owed_results.size();
    end

endmodule

`default_nettype wire

// ===== verif/tb_bounded_recency_list_push.sv =====
// testbench top for bounded_recency_list_push: clock, reset, key and limit stimulus
// depends on brlp_pkg, bounded_recency_list_push and brlp_push_checker
`default_nettype none

module tb_bounded_recency_list_push;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IN_W      = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int OUT_W     = ((KEY_WIDTH + 11 + 7) / 8) * 8;
    localparam int POOL_MAX  = 24;

    localparam logic [KEY_WIDTH-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_WIDTH-1:0] KEY_MAX  = 32'h7fff_ffff;
    localparam logic [KEY_WIDTH-1:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [KEY_WIDTH-1:0] KEY_ONES = 32'hffff_ffff;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [brlp_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [IN_W-1:0]            s_tdata     = '0;
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [OUT_W-1:0]           m_tdata;

    int                   mismatch_count;
    int                   results_owed;
    int                   send_gap_pct  = 15;
    int                   stall_pct     = 15;
    logic [KEY_WIDTH-1:0] key_pool [POOL_MAX];
    int                   pool_size     = 1;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    bounded_recency_list_push #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    brlp_push_checker #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // result side stalls in bursts
    always begin
        @(negedge aclk);
        if ($urandom_range(1, 100) <= stall_pct) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    initial begin
        #(12 * 300_000);
        $display("Verification failed");
        $finish;
    end

    task automatic send_key(input logic [KEY_WIDTH-1:0] key);
        if ($urandom_range(1, 100) <= send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (results_owed != 0) @(negedge aclk);
    endtask

    // only written with nothing in flight
    task automatic set_limit(input logic [brlp_pkg::CFG_W-1:0] lim);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic refresh_pool();
        int i;
        pool_size = $urandom_range(2, POOL_MAX);
        for (i = 0; i < pool_size; i++) begin
            case ($urandom_range(0, 9))
                0:       key_pool[i] = KEY_MIN;
                1:       key_pool[i] = KEY_MAX;
                2:       key_pool[i] = KEY_ZERO;
                3:       key_pool[i] = KEY_ONES;
                default: key_pool[i] = $urandom();
            endcase
        end
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    task automatic run_phase(input logic [brlp_pkg::CFG_W-1:0] lim, input int beats);
        set_limit(lim);
        refresh_pool();
        repeat (beats) send_key(pick_key());
    endtask

    initial begin
        int i;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset limit of 16: extremes, hits at oldest, middle and newest, then overflow
        send_key(KEY_MIN);
        send_key(KEY_MAX);
        send_key(KEY_ZERO);
        send_key(KEY_ONES);
        send_key(32'd1);
        send_key(KEY_MIN);
        send_key(KEY_ONES);
        send_key(KEY_ONES);
        for (i = 2; i < 14; i++)
            send_key(i);
        send_key(KEY_ZERO);
        // a limit of zero acts as one: a full list collapses in a single push
        set_limit(5'd0);
        send_key(32'h1234_5678);
        send_key(32'h1234_5678);

        // random part, limits include the extremes and the out-of-range values
        run_phase(5'd16, 205);
        run_phase(5'd1, 205);
        send_gap_pct = 0;
        stall_pct    = 0;
        run_phase(5'd31, 205);
        send_gap_pct = 25;
        stall_pct    = 25;
        run_phase(5'd17, 205);
        run_phase(5'd3, 205);
        run_phase(5'd16, 205);
        run_phase(5'($urandom_range(2, 15)), 205);
        send_gap_pct = 0;
        stall_pct    = 0;
        run_phase(5'($urandom_range(0, 31)), 300);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/brlp_pkg.sv
design/brlp_cell.sv
design/bounded_recency_list_push.sv
verif/brlp_push_checker.sv
verif/tb_bounded_recency_list_push.sv
